### sv/sntiu_pkg.sv
// ----------------------------------------------------------------------------
// sntiu_pkg
// Types, constants and the sigmoid table function shared by the neuron unit.
// ----------------------------------------------------------------------------
package sntiu_pkg;

	localparam logic [1:0] OP_FWD     = 2'd0;
	localparam logic [1:0] OP_TRAIN   = 2'd1;
	localparam logic [1:0] OP_LOAD    = 2'd2;
	localparam logic [1:0] OP_IGNORED = 2'd3;

	localparam logic [1:0] KIND_FWD   = 2'd0;
	localparam logic [1:0] KIND_TRAIN = 2'd1;
	localparam logic [1:0] KIND_LOAD  = 2'd2;

	localparam logic CFG_LEARN_RATE    = 1'b0;
	localparam logic CFG_ACTIVE_INPUTS = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_MUL1,
		ST_MUL2,
		ST_MUL3,
		ST_WRITE,
		ST_OUT
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic clear;
		logic capture;
		logic rd_en;
		logic mul1;
		logic mul2;
		logic mul3;
		logic commit;
		logic out_load;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic last;
		logic op_ignored;
		logic clear_done;
	} dp_sts_t;

	// unsigned quotient by shift and subtract (elaboration only)
	function automatic longint unsigned udiv(input longint unsigned n,
			input longint unsigned dv);
		longint unsigned q;
		longint unsigned r;
		q = 0;
		r = 0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[62:0], n[b]};
			if (r >= dv) begin
				r = r - dv;
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// e^-f, Q0.32, f in Q.24 (elaboration only)
	function automatic longint unsigned exp_frac(input longint unsigned f);
		longint unsigned pos;
		longint unsigned neg;
		longint unsigned term;
		pos = 64'd1 << 32;
		neg = 0;
		term = 64'd1 << 32;
		for (int k = 1; k <= 24; k++) begin
			term = udiv((term * f) >> 24, longint'(k));
			if ((k & 1) == 1) begin
				neg += term;
			end else begin
				pos += term;
			end
		end
		return pos - neg;
	endfunction

	function automatic logic [15:0] sig_entry(input int i, input int Entries);
		longint num;
		logic negt;
		longint unsigned mag;
		longint unsigned a;
		longint unsigned e;
		longint unsigned e1;
		longint unsigned d;
		longint unsigned v;
		longint unsigned n;
		num = 32 * longint'(i) + 16 - 16 * longint'(Entries);
		negt = num < 0;
		mag = negt ? longint'(-num) : num;
		a = udiv(mag << 23, longint'(Entries));
		e = exp_frac(a & 64'hFFFFFF);
		e1 = exp_frac(64'd1 << 24);
		n = (a >> 24) & 64'd7;
		for (int j = 0; j < 8; j++) begin
			if (longint'(j) < n) begin
				e = (e * e1) >> 32;
			end
		end
		d = (64'd1 << 32) + e;
		if (!negt) begin
			v = udiv((64'd1 << 48) + (d >> 1), d);
		end else begin
			v = udiv((e << 16) + (d >> 1), d);
		end
		return (v > 64'd65535) ? 16'hFFFF : v[15:0];
	endfunction

endpackage

### sv/sntiu_ram.sv
// ----------------------------------------------------------------------------
// sntiu_ram
// Generic RAM with one write port, one read port and registered read.
// ----------------------------------------------------------------------------
module sntiu_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

### sv/sntiu_ctrl.sv
// ----------------------------------------------------------------------------
// sntiu_ctrl
// Sequencer: RAM clear, then per element read weight, three multiply steps, commit, emit on last.
// ----------------------------------------------------------------------------
module sntiu_ctrl
	import sntiu_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	output dp_cmd_t cmd,
	input  dp_sts_t sts
);
	state_t state_q, state_d;
	logic   pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				pend_q <= 1'b1;
			end else if (out_ready) begin
				pend_q <= 1'b0;
			end
		end
	end

	assign out_valid = pend_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (sts.clear_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_READ;
				end
			end
			ST_READ:  state_d = sts.op_ignored ? ST_IDLE : ST_MUL1;
			ST_MUL1:  state_d = ST_MUL2;
			ST_MUL2:  state_d = ST_MUL3;
			ST_MUL3:  state_d = ST_WRITE;
			ST_WRITE: state_d = sts.last ? ST_OUT : ST_IDLE;
			ST_OUT: begin
				// hold until the previous result is taken
				if (!pend_q || out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd = '0;
		case (state_q)
			ST_CLEAR: cmd.clear = 1'b1;
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.capture = in_valid;
				cmd.rd_en = in_valid;
			end
			ST_MUL1:  cmd.mul1 = 1'b1;
			ST_MUL2:  cmd.mul2 = 1'b1;
			ST_MUL3:  cmd.mul3 = 1'b1;
			ST_WRITE: cmd.commit = 1'b1;
			ST_OUT:   cmd.out_load = !pend_q || out_ready;
			default: ;
		endcase
	end
endmodule

### sv/sntiu_dp.sv
// ----------------------------------------------------------------------------
// sntiu_dp
// Datapath: weight RAM, bias, accumulator, multiplier chain, sigmoid lookup.
// ----------------------------------------------------------------------------
module sntiu_dp
	import sntiu_pkg::*;
#(
	parameter int NUM_WEIGHTS     = 64,
	parameter int SIGMOID_ENTRIES = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_idx,
	input  logic [15:0]        cfg_data,
	input  logic [1:0]         op,
	input  logic signed [15:0] x,
	input  logic signed [15:0] cost_grad,
	input  logic signed [15:0] pred_grad,
	input  logic               last,
	input  dp_cmd_t            cmd,
	output dp_sts_t            sts,
	output logic [15:0]        activation,
	output logic signed [19:0] weighted_sum,
	output logic [1:0]         kind
);
	localparam int IW = $clog2(NUM_WEIGHTS + 1);
	localparam int AW = (NUM_WEIGHTS > 1) ? $clog2(NUM_WEIGHTS) : 1;
	localparam int TW = $clog2(SIGMOID_ENTRIES);

	logic [15:0]        lr_q;
	logic [6:0]         act_q;
	logic [IW-1:0]      idx_q;
	logic signed [15:0] bias_q;
	logic signed [39:0] acc_q;

	logic [1:0]         op_q;
	logic signed [15:0] x_q, cg_q, pg_q;
	logic               last_q, inuse_q;
	logic [AW-1:0]      addr_q;
	logic [AW-1:0]      clr_q;
	logic signed [31:0] g_q;
	logic signed [31:0] p_q;     // x*w or x*lr
	logic signed [63:0] t_q;     // lr*x*g
	logic [15:0]        rdata;
	logic signed [15:0] wr_val;
	logic               wr_en;
	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [15:0]        ram_wdata;

	// effective active count, as wide as IW+7
	logic [IW+6:0] eff;
	always_comb begin
		if ({{IW{1'b0}}, act_q} > (IW+7)'(NUM_WEIGHTS)) begin
			eff = (IW+7)'(NUM_WEIGHTS);
		end else begin
			eff = {{IW{1'b0}}, act_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lr_q  <= 16'd655;
			act_q <= 7'd64;
		end else if (cfg_we) begin
			if (cfg_idx == CFG_LEARN_RATE) begin
				lr_q <= cfg_data;
			end else begin
				act_q <= cfg_data[6:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q    <= op;
			x_q     <= x;
			cg_q    <= cost_grad;
			pg_q    <= pred_grad;
			last_q  <= last;
			inuse_q <= {7'd0, idx_q} < eff;
			addr_q  <= AW'(idx_q);
		end
	end

	assign sts.last       = last_q;
	assign sts.op_ignored = (op_q == OP_IGNORED);
	assign sts.clear_done = (clr_q == AW'(NUM_WEIGHTS - 1));

	// weight store is zeroed by a clearing pass after reset
	logic signed [15:0] w;
	assign w = rdata;

	assign ram_we    = wr_en || cmd.clear;
	assign ram_waddr = cmd.clear ? clr_q : addr_q;
	assign ram_wdata = cmd.clear ? 16'd0 : wr_val;

	sntiu_ram #(.WIDTH(16), .DEPTH(NUM_WEIGHTS)) u_wram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (cmd.rd_en),
		.raddr(AW'(idx_q)),
		.rdata(rdata)
	);

	// bias term lr*g, computed in the mul3 slot
	logic signed [63:0] bterm_q;

	// multiply chain
	always_ff @(posedge clk) begin
		if (cmd.mul1) begin
			g_q <= cg_q * pg_q;
			if (op_q == OP_FWD) begin
				p_q <= x_q * w;
			end else begin
				p_q <= x_q * $signed({1'b0, lr_q});
			end
		end
		if (cmd.mul2) begin
			if (op_q == OP_TRAIN && !inuse_q) begin
				t_q <= 64'sd0;
			end else begin
				t_q <= p_q * g_q;
			end
		end
		if (cmd.mul3) begin
			bterm_q <= $signed({1'b0, lr_q}) * g_q;
		end
	end

	// commit logic
	logic signed [63:0] wd, bd;
	logic signed [40:0] acc_sum;
	logic signed [39:0] acc_new;
	logic signed [23:0] wnew, bnew;
	assign wd = (t_q + (64'sd1 <<< 39)) >>> 40;
	assign bd = (bterm_q + (64'sd1 <<< 27)) >>> 28;
	assign wnew = 24'(w) - 24'(wd);
	assign bnew = 24'(bias_q) - 24'(bd);
	assign acc_sum = 41'(acc_q) + 41'(p_q);

	always_comb begin
		if (acc_sum > 41'sd549755813887) begin
			acc_new = 40'sh7F_FFFF_FFFF;
		end else if (acc_sum < -41'sd549755813888) begin
			acc_new = 40'sh80_0000_0000;
		end else begin
			acc_new = acc_sum[39:0];
		end
	end

	function automatic logic signed [15:0] s16(input logic signed [23:0] v);
		if (v > 24'sd32767) begin
			return 16'sh7FFF;
		end else if (v < -24'sd32768) begin
			return 16'sh8000;
		end
		return v[15:0];
	endfunction

	always_comb begin
		wr_en  = 1'b0;
		wr_val = x_q;
		if (cmd.commit && inuse_q) begin
			if (op_q == OP_TRAIN) begin
				wr_en  = 1'b1;
				wr_val = s16(wnew);
			end else if (op_q == OP_LOAD && !last_q) begin
				wr_en = 1'b1;
			end
		end
	end

	// forward sum: acc after this element plus bias
	logic signed [39:0] acc_fwd_q;
	logic signed [40:0] sum;
	logic signed [28:0] sh;
	logic signed [19:0] ws;
	logic signed [20:0] pos;
	logic [TW-1:0]      ti;
	assign sum = 41'(acc_fwd_q) + {{13{bias_q[15]}}, bias_q, 12'd0};
	assign sh  = 29'(sum >>> 12);
	always_comb begin
		if (sh > 29'sd524287) begin
			ws = 20'sh7FFFF;
		end else if (sh < -29'sd524288) begin
			ws = 20'sh80000;
		end else begin
			ws = sh[19:0];
		end
		pos = 21'(ws) + 21'sd32768;
		if (pos < 0) begin
			ti = '0;
		end else if (pos > 21'sd65535) begin
			ti = TW'(SIGMOID_ENTRIES - 1);
		end else begin
			ti = TW'((32'(pos[15:0]) * 32'(SIGMOID_ENTRIES)) >> 16);
		end
	end

	logic [15:0] sig_tab [SIGMOID_ENTRIES];
	for (genvar gi = 0; gi < SIGMOID_ENTRIES; gi++) begin : g_sig
		localparam logic [15:0] ENTRY = sig_entry(gi, SIGMOID_ENTRIES);
		assign sig_tab[gi] = ENTRY;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			bias_q    <= '0;
			acc_q     <= '0;
			acc_fwd_q <= '0;
			clr_q     <= '0;
		end else begin
			if (cmd.clear) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd.commit && op_q != OP_IGNORED) begin
				if (op_q == OP_FWD) begin
					acc_fwd_q <= inuse_q ? acc_new : acc_q;
				end
				if (last_q) begin
					acc_q <= '0;
					idx_q <= '0;
					if (op_q == OP_TRAIN) begin
						bias_q <= s16(bnew);
					end else if (op_q == OP_LOAD) begin
						bias_q <= x_q;
					end
				end else begin
					if (op_q == OP_FWD && inuse_q) begin
						acc_q <= acc_new;
					end
					if (idx_q < IW'(NUM_WEIGHTS)) begin
						idx_q <= idx_q + 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			kind <= op_q;
			if (op_q == OP_FWD) begin
				activation   <= sig_tab[ti];
				weighted_sum <= ws;
			end else begin
				activation   <= '0;
				weighted_sum <= '0;
			end
		end
	end
endmodule

### sv/sigmoid_neuron_train_infer_unit.sv
// ----------------------------------------------------------------------------
// sigmoid_neuron_train_infer_unit
// Single sigmoid neuron: forward inference, SGD training and weight load.
// ----------------------------------------------------------------------------
// Each element passes through capture with weight RAM read, read wait, three
// multiply steps and commit; after the last element the result is posted, later
// while the previous result is still held. No new element is taken until the
// current one is through. Op 3 goes back to idle after the read wait, uncommitted.
// Reset zeroes bias, accumulator and index, sets learn_rate 655 and active_inputs
// 64, then clears the weight RAM with in_ready low.
module sigmoid_neuron_train_infer_unit
	import sntiu_pkg::*;
#(
	parameter int NUM_WEIGHTS     = 64,
	parameter int SIGMOID_ENTRIES = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         op,
	input  logic signed [15:0] x,
	input  logic signed [15:0] cost_grad,
	input  logic signed [15:0] pred_grad,
	input  logic               last,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [15:0]        activation,
	output logic signed [19:0] weighted_sum,
	output logic [1:0]         kind
);
	dp_cmd_t cmd;
	dp_sts_t sts;

	assign cfg_ready = 1'b1;

	sntiu_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready),
		.cmd(cmd), .sts(sts)
	);

	sntiu_dp #(.NUM_WEIGHTS(NUM_WEIGHTS), .SIGMOID_ENTRIES(SIGMOID_ENTRIES)) u_dp (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_valid), .cfg_idx(cfg_index), .cfg_data(cfg_data),
		.op(op), .x(x), .cost_grad(cost_grad), .pred_grad(pred_grad), .last(last),
		.cmd(cmd), .sts(sts),
		.activation(activation), .weighted_sum(weighted_sum), .kind(kind)
	);

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.capture, cmd.mul1, cmd.mul2, cmd.mul3, cmd.commit, cmd.out_load}))
		else $error("more than one datapath command");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mul1 |-> !in_ready)
		else $error("input accepted mid element");

	a_out_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid)
		else $error("result not posted");
endmodule

### bench/sigmoid_neuron_train_infer_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sigmoid_neuron_train_infer_unit_tb
// Drives forward, train, load and op-3 vectors and config writes with random
// handshake gaps; checks every result against a bit-accurate predictor in the bench.
// ----------------------------------------------------------------------------
module sigmoid_neuron_train_infer_unit_tb;
	import sntiu_pkg::*;

	localparam int NW = 64;
	localparam int NE = 256;

	typedef struct packed {
		logic [1:0]         op;
		logic signed [15:0] x;
		logic signed [15:0] cg;
		logic signed [15:0] pg;
		logic               last;
	} elem_t;

	typedef struct packed {
		logic [15:0]        act;
		logic signed [19:0] ws;
		logic [1:0]         kind;
	} res_t;

	// stimulus entries: mode 0 element, 1 config write, 2 drain barrier
	typedef struct packed {
		logic [1:0]  mode;
		elem_t       e;
		logic        ci;
		logic [15:0] cd;
	} job_t;

	logic clk;
	logic arst_n;
	logic cfg_valid, cfg_ready, cfg_index;
	logic [15:0] cfg_data;
	logic in_valid, in_ready;
	logic [1:0] op;
	logic signed [15:0] x, cost_grad, pred_grad;
	logic last;
	logic out_valid, out_ready;
	logic [15:0] activation;
	logic signed [19:0] weighted_sum;
	logic [1:0] kind;

	sigmoid_neuron_train_infer_unit uut (.*);

	// predictor state
	logic [15:0] m_lr;
	logic [6:0]  m_active;
	logic signed [15:0] m_w[NW];
	logic signed [15:0] m_bias;
	longint m_acc;
	int m_idx;
	logic [15:0] sig_lut[NE];

	job_t jobs[$];
	res_t expected_results[$];
	int errors = 0;
	bit stim_done = 0;
	bit quiet = 0;
	int in_gap = 0, out_gap = 0, cfg_wait = 0;

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("sigmoid_neuron_train_infer_unit_tb: FAIL");
		$finish;
	end

	// e^-f Q0.32, independent series evaluation
	function automatic longint unsigned neg_exp_frac(longint unsigned f);
		longint unsigned p, n, t;
		p = 64'd1 << 32;
		n = 0;
		t = 64'd1 << 32;
		for (int k = 1; k <= 24; k++) begin
			t = ((t * f) >> 24) / k;
			if (k & 1) n += t;
			else p += t;
		end
		return p - n;
	endfunction

	function automatic logic [15:0] lut_value(int i);
		longint num;
		longint unsigned mag, a, e, e1, d, v;
		bit neg;
		num = 32 * longint'(i) + 16 - 16 * NE;
		neg = num < 0;
		mag = neg ? -num : num;
		a = (mag << 23) / NE;
		e = neg_exp_frac(a & 64'hFFFFFF);
		e1 = neg_exp_frac(64'd1 << 24);
		for (longint unsigned j = 0; j < ((a >> 24) & 7); j++) e = (e * e1) >> 32;
		d = (64'd1 << 32) + e;
		v = neg ? ((e << 16) + d / 2) / d : ((64'd1 << 48) + d / 2) / d;
		return v > 65535 ? 16'hFFFF : v[15:0];
	endfunction

	function automatic longint floor_sh(longint v, int s);
		return v >>> s;
	endfunction

	function automatic logic signed [15:0] clip16(longint v);
		return v < -32768 ? -16'sd32768 : (v > 32767 ? 16'sd32767 : v[15:0]);
	endfunction

	task automatic neuron_step(elem_t e);
		int eff;
		bit used;
		longint g, d, s, wsum, pos;
		int ti;
		res_t r;
		if (e.op == 2'd3) return;
		eff = m_active > NW ? NW : m_active;
		used = m_idx < eff;
		r = '0;
		if (e.op == OP_FWD) begin
			if (used) begin
				m_acc = m_acc + longint'(e.x) * longint'(m_w[m_idx]);
				if (m_acc > (64'sd1 <<< 39) - 1) m_acc = (64'sd1 <<< 39) - 1;
				if (m_acc < -(64'sd1 <<< 39)) m_acc = -(64'sd1 <<< 39);
			end
			if (e.last) begin
				s = m_acc + longint'(m_bias) * 4096;
				wsum = floor_sh(s, 12);
				if (wsum > 524287) wsum = 524287;
				if (wsum < -524288) wsum = -524288;
				pos = wsum + 32768;
				ti = pos < 0 ? 0 : (pos > 65535 ? NE - 1 : int'((pos * NE) >> 16));
				r.act = sig_lut[ti];
				r.ws = wsum[19:0];
				r.kind = KIND_FWD;
				expected_results.push_back(r);
			end
		end else if (e.op == OP_TRAIN) begin
			g = longint'(e.cg) * longint'(e.pg);
			if (used) begin
				d = floor_sh(longint'(m_lr) * longint'(e.x) * g + (64'sd1 <<< 39), 40);
				m_w[m_idx] = clip16(longint'(m_w[m_idx]) - d);
			end
			if (e.last) begin
				d = floor_sh(longint'(m_lr) * g + (64'sd1 <<< 27), 28);
				m_bias = clip16(longint'(m_bias) - d);
				r.kind = KIND_TRAIN;
				expected_results.push_back(r);
			end
		end else begin
			if (e.last) begin
				m_bias = e.x;
				r.kind = KIND_LOAD;
				expected_results.push_back(r);
			end else if (used) begin
				m_w[m_idx] = e.x;
			end
		end
		if (e.last) begin
			m_idx = 0;
			m_acc = 0;
		end else if (m_idx < NW) begin
			m_idx++;
		end
	endtask

	function automatic logic signed [15:0] rand_val(int sel);
		case (sel)
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return $urandom_range(0, 8191) - 4096;
			default: return $urandom;
		endcase
	endfunction

	task automatic add_elem(logic [1:0] o, logic signed [15:0] xv, logic signed [15:0] c,
			logic signed [15:0] p, logic l);
		job_t j;
		j = '0;
		j.e = '{o, xv, c, p, l};
		jobs.push_back(j);
	endtask

	task automatic add_cfg(logic ci, logic [15:0] cd);
		job_t j;
		j = '0;
		j.mode = 2'd2;
		jobs.push_back(j);
		j.mode = 2'd1;
		j.ci = ci;
		j.cd = cd;
		jobs.push_back(j);
	endtask

	task automatic add_vector(int len, int o);
		int sel;
		sel = $urandom_range(0, 3);
		for (int k = 0; k < len; k++)
			add_elem(o, rand_val(sel == 3 ? $urandom_range(0, 3) : 2), rand_val(sel),
				rand_val($urandom_range(0, 3)), k == len - 1);
	endtask

	initial begin
		int n, o;
		for (int i = 0; i < NE; i++) sig_lut[i] = lut_value(i);
		m_lr = 655;
		m_active = 64;
		for (int i = 0; i < NW; i++) m_w[i] = 0;
		m_bias = 0;
		m_acc = 0;
		m_idx = 0;

		// directed: forward on zero state, load extremes, train, ignored op
		add_elem(OP_FWD, 16'sh7FFF, 0, 0, 1);
		add_elem(OP_LOAD, 16'sh7FFF, 0, 0, 0);
		add_elem(OP_LOAD, 16'sh8000, 0, 0, 0);
		add_elem(OP_LOAD, 16'sh7FFF, 0, 0, 1);
		add_elem(OP_FWD, 16'sh7FFF, 0, 0, 0);
		add_elem(2'd3, 16'sh1234, 0, 0, 1);
		add_elem(OP_FWD, 16'sh8000, 0, 0, 1);
		add_elem(OP_TRAIN, 16'sh7FFF, 16'sh8000, 16'sh8000, 0);
		add_elem(OP_TRAIN, 16'sh8000, 16'sh7FFF, 16'sh8000, 1);
		add_elem(OP_LOAD, 16'sh8000, 0, 0, 1);
		add_elem(OP_FWD, 16'sh0100, 0, 0, 0);
		add_elem(OP_TRAIN, 16'sh1000, 16'sh1000, 16'sh1000, 0);
		add_elem(OP_FWD, 16'sh0100, 0, 0, 1);
		add_cfg(CFG_LEARN_RATE, 16'hFFFF);
		add_cfg(CFG_ACTIVE_INPUTS, 16'd1);
		add_elem(OP_TRAIN, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 0);
		add_elem(OP_TRAIN, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1);
		add_elem(OP_FWD, 16'sh7FFF, 0, 0, 0);
		add_elem(OP_FWD, 16'sh7FFF, 0, 0, 1);
		add_cfg(CFG_ACTIVE_INPUTS, 16'd0);
		add_elem(OP_FWD, 16'sh7FFF, 0, 0, 1);
		add_cfg(CFG_LEARN_RATE, 16'd0);
		add_elem(OP_TRAIN, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1);

		// random phases; most vectors short, a few overrun the weight count
		n = 0;
		for (int ph = 0; n < 1050; ph++) begin
			add_cfg(CFG_LEARN_RATE, ph % 4 == 0 ? 16'hFFFF : $urandom);
			add_cfg(CFG_ACTIVE_INPUTS, ph % 5 == 0 ? 16'd64 :
				(ph % 5 == 1 ? 16'd1 : $urandom_range(0, 127)));
			for (int v = 0; v < 12; v++) begin
				int len;
				len = $urandom_range(0, 19) == 0 ? $urandom_range(60, 70) : $urandom_range(1, 6);
				o = $urandom_range(0, 9);
				o = o < 4 ? OP_FWD : (o < 7 ? OP_TRAIN : (o < 9 ? OP_LOAD : 3));
				if ($urandom_range(0, 15) == 0)
					add_elem($urandom_range(0, 3), $urandom, $urandom, $urandom, $urandom);
				add_vector(len, o);
				n += len;
			end
		end
		stim_done = 1;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 0;
			cfg_valid <= 0;
			op <= 0;
			x <= 0;
			cost_grad <= 0;
			pred_grad <= 0;
			last <= 0;
			cfg_index <= 0;
			cfg_data <= 0;
			in_gap <= 0;
		end else begin
			if (in_valid && in_ready) neuron_step('{op, x, cost_grad, pred_grad, last});
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_LEARN_RATE) m_lr = cfg_data;
				else m_active = cfg_data[6:0];
			end
			if ((in_valid && !in_ready) || (cfg_valid && !cfg_ready)) begin
				// hold until accepted
			end else if (in_gap > 0) begin
				in_valid <= 0;
				cfg_valid <= 0;
				in_gap <= in_gap - 1;
			end else if (jobs.size() == 0) begin
				in_valid <= 0;
				cfg_valid <= 0;
			end else if (jobs[0].mode == 2'd2) begin
				in_valid <= 0;
				cfg_valid <= 0;
				if (expected_results.size() == 0 && !(in_valid && in_ready)) begin
					if (cfg_wait >= 12) begin
						void'(jobs.pop_front());
						cfg_wait <= 0;
					end else begin
						cfg_wait <= cfg_wait + 1;
					end
				end
			end else begin
				job_t j;
				j = jobs.pop_front();
				if (j.mode == 2'd1) begin
					in_valid <= 0;
					cfg_valid <= 1;
					cfg_index <= j.ci;
					cfg_data <= j.cd;
				end else begin
					cfg_valid <= 0;
					in_valid <= 1;
					{op, x, cost_grad, pred_grad, last} <= j.e;
				end
				if (!quiet && $urandom_range(0, 5) == 0) in_gap <= $urandom_range(1, 7);
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 0;
			out_gap <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result act=%h ws=%h kind=%0d", $realtime,
						activation, weighted_sum, kind);
					errors++;
				end else begin
					res_t r;
					r = expected_results.pop_front();
					if (r.act !== activation || r.ws !== weighted_sum || r.kind !== kind) begin
						$display("%0t: mismatch expected act=%h ws=%h kind=%0d actual act=%h ws=%h kind=%0d",
							$realtime, r.act, r.ws, r.kind, activation, weighted_sum, kind);
						errors++;
					end
				end
			end
			if (out_gap > 0) begin
				out_ready <= 0;
				out_gap <= out_gap - 1;
			end else begin
				out_ready <= 1;
				if (!quiet && $urandom_range(0, 5) == 0) out_gap <= $urandom_range(1, 7);
			end
		end
	end

	initial begin
		arst_n = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		wait (stim_done);
		// no idling in the tail of the run
		wait (jobs.size() < 150);
		quiet = 1;
		wait (jobs.size() == 0 && !in_valid && !cfg_valid);
		wait (expected_results.size() == 0);
		repeat (20) @(posedge clk);
		if (errors == 0 && expected_results.size() == 0) begin
			$display("sigmoid_neuron_train_infer_unit_tb: PASS");
		end else begin
			$display("sigmoid_neuron_train_infer_unit_tb: FAIL");
		end
		$finish;
	end

endmodule
